// ===== rtl/line_follow_steering_pid_defines.svh =====
// Assertion macros used by the steering PID checker.
`ifndef LINE_FOLLOW_STEERING_PID_DEFINES_SVH
`define LINE_FOLLOW_STEERING_PID_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LFSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("steering pid check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LFSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("steering pid check failed");

`endif

// ===== rtl/lfsp_pkg.sv =====
// Types, codes and constants of the line follower steering PID.
`default_nettype none

package lfsp_pkg;

    // shared multiplier geometry
    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 36;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_I   = 3'd1;
    localparam logic [2:0] CFG_GAIN_D   = 3'd2;
    localparam logic [2:0] CFG_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_HEADROOM = 3'd4;
    localparam logic [2:0] CFG_TRIM     = 3'd5;

    // configuration reset values
    localparam logic [15:0]       GAIN_P_RST   = 16'd256;
    localparam logic [15:0]       GAIN_I_RST   = 16'd0;
    localparam logic [15:0]       GAIN_D_RST   = 16'd0;
    localparam logic [8:0]        LIMIT_RST    = 9'd300;
    localparam logic [7:0]        HEADROOM_RST = 8'd50;
    localparam logic signed [7:0] TRIM_RST     = -8'sd3;

    // direction commands
    localparam logic [2:0] DIR_RIGHT    = 3'd0;
    localparam logic [2:0] DIR_STRAIGHT = 3'd1;
    localparam logic [2:0] DIR_LEFT     = 3'd2;
    localparam logic [2:0] DIR_STOP     = 3'd3;

    // sensor patterns (bit 0 leftmost)
    localparam logic [4:0] SENS_R4     = 5'h10;
    localparam logic [4:0] SENS_R3     = 5'h18;
    localparam logic [4:0] SENS_R2     = 5'h08;
    localparam logic [4:0] SENS_R1     = 5'h0C;
    localparam logic [4:0] SENS_CENTRE = 5'h04;
    localparam logic [4:0] SENS_L1     = 5'h06;
    localparam logic [4:0] SENS_L2     = 5'h02;
    localparam logic [4:0] SENS_L3     = 5'h03;
    localparam logic [4:0] SENS_L4     = 5'h01;
    localparam logic [4:0] SENS_HARD_L = 5'h07;
    localparam logic [4:0] SENS_HARD_R = 5'h1C;
    localparam logic [4:0] SENS_FULL   = 5'h1F;
    localparam logic [4:0] SENS_NONE   = 5'h00;
    localparam logic [4:0] SENS_ENDS   = 5'h11;

    localparam logic signed [4:0] ERR_CROSS_RIGHT = 5'sd5;
    localparam logic signed [4:0] ERR_CROSS_LEFT  = -5'sd5;

    // integral decay: x 243/256 above 10 whole units (Q.8)
    localparam logic signed [MUL_W-1:0] DECAY_NUM   = 19'sd243;
    localparam logic [17:0]             DECAY_FLOOR = 18'd2560;

    typedef logic signed [4:0] t_err;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DECODE,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_DECAY,
        OP_STEER,
        OP_WL_SONAR,
        OP_WL_TRIM,
        OP_WR_SONAR,
        OP_WR_TRIM
    } t_op;

    typedef struct packed {
        logic load_in;
        logic load_out;
        t_op  op;
    } t_dp_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_DECAY,
        S_STEER,
        S_WL_SONAR,
        S_WL_TRIM,
        S_WR_SONAR,
        S_WR_TRIM,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/lfsp_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none

module lfsp_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [lfsp_pkg::MUL_W-1:0]     i_a,
    input  logic signed [lfsp_pkg::MUL_W-1:0]     i_b,
    output logic signed [lfsp_pkg::PROD_W-1:0]    o_prod
);

    logic signed [lfsp_pkg::PROD_W-1:0] r_prod;
    logic signed [lfsp_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = r_prod;
        if (i_en) begin
            n_prod = i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/lfsp_dp.sv =====
// Datapath: sensor decode, integral, PID sum and wheel mixing.
`default_nettype none

module lfsp_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lfsp_pkg::t_dp_cmd       i_cmd,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    input  logic [4:0]              i_line_sensors,
    input  logic [2:0]              i_direction,
    input  logic [7:0]              i_drive_speed,
    input  logic [8:0]              i_sonar_factor,
    input  logic                    i_maneuver_armed,
    output logic signed [4:0]       o_direction_error,
    output logic signed [10:0]      o_steer_value,
    output logic [7:0]              o_left_speed,
    output logic [7:0]              o_right_speed,
    output logic                    o_action_done,
    output logic                    o_in_full_line
);

    // latched transaction
    logic [4:0]  r_sens;
    logic [2:0]  r_dir;
    logic [7:0]  r_speed;
    logic [8:0]  r_sonar;
    logic        r_armed;

    // configuration
    logic [15:0]       r_gain_p, r_gain_i, r_gain_d;
    logic [8:0]        r_int_limit;
    logic [7:0]        r_headroom;
    logic signed [7:0] r_trim;

    // loop state
    logic                r_cross, n_cross;
    lfsp_pkg::t_err      r_held, n_held;
    lfsp_pkg::t_err      r_prior, n_prior;
    logic signed [17:0]  r_integ, n_integ;

    // working registers
    logic                               r_done, n_done;
    logic signed [5:0]                  r_diff, n_diff;
    logic signed [lfsp_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic signed [10:0]                 r_steer, n_steer;
    logic [7:0]                         r_left, n_left;

    // result register
    lfsp_pkg::t_err      r_out_err;
    logic signed [10:0]  r_out_steer;
    logic [7:0]          r_out_left, r_out_right;
    logic                r_out_done, r_out_full;

    // decode
    lfsp_pkg::t_err     dec_err;
    logic               dec_cross, dec_done;
    logic signed [19:0] int_sum, int_lim;
    logic signed [17:0] int_clamped;

    // multiplier
    logic                                mul_en;
    logic signed [lfsp_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [lfsp_pkg::PROD_W-1:0]  mul_prod;

    // steering, decay, wheels
    logic signed [lfsp_pkg::ACC_W-1:0]  acc_rnd;
    logic signed [19:0]                 steer_q;
    logic [17:0]                        int_abs;
    logic [24:0]                        decay_rnd;
    logic [8:0]                         wheel_top, wheel_l, wheel_r;
    logic signed [11:0]                 raw_l, raw_r;
    logic [9:0]                         fac_l, fac_r;

    function automatic logic [8:0] wheel_clamp(input logic signed [11:0] raw,
                                               input logic [8:0] top);
        logic [8:0] v;
        if (raw[11]) begin
            v = 9'd0;
        end else if (raw > $signed({3'b000, top})) begin
            v = top;
        end else begin
            v = raw[8:0];
        end
        return v;
    endfunction

    function automatic logic [7:0] sat_speed(input logic signed [lfsp_pkg::PROD_W-1:0] p);
        logic [7:0] s;
        if (p[lfsp_pkg::PROD_W-1:24] != '0) begin
            s = 8'hFF;
        end else begin
            s = p[23:16];
        end
        return s;
    endfunction

    lfsp_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // sensor decode and full-line mode
    always_comb begin
        dec_err   = r_held;
        dec_cross = r_cross;
        dec_done  = 1'b0;
        if (!r_cross) begin
            unique case (r_sens)
                lfsp_pkg::SENS_R4:     dec_err = 5'sd4;
                lfsp_pkg::SENS_R3:     dec_err = 5'sd3;
                lfsp_pkg::SENS_R2:     dec_err = 5'sd2;
                lfsp_pkg::SENS_R1:     dec_err = 5'sd1;
                lfsp_pkg::SENS_CENTRE: dec_err = 5'sd0;
                lfsp_pkg::SENS_L1:     dec_err = -5'sd1;
                lfsp_pkg::SENS_L2:     dec_err = -5'sd2;
                lfsp_pkg::SENS_L3:     dec_err = -5'sd3;
                lfsp_pkg::SENS_L4:     dec_err = -5'sd4;
                lfsp_pkg::SENS_HARD_L: dec_err = -5'sd10;
                lfsp_pkg::SENS_HARD_R: dec_err = 5'sd10;
                lfsp_pkg::SENS_FULL:   dec_cross = 1'b1;
                lfsp_pkg::SENS_NONE: begin
                    // line lost off an outer sensor
                    if (r_held == -5'sd4) begin
                        dec_err = -5'sd5;
                    end else if (r_held == 5'sd4) begin
                        dec_err = 5'sd5;
                    end
                end
                default: ;
            endcase
        end
        if (dec_cross) begin
            if ((((r_sens & lfsp_pkg::SENS_ENDS) == 5'h00) || (r_dir == lfsp_pkg::DIR_STOP))
                && r_armed) begin
                dec_cross = 1'b0;
                dec_done  = 1'b1;
            end
            unique case (r_dir)
                lfsp_pkg::DIR_RIGHT:    dec_err = lfsp_pkg::ERR_CROSS_RIGHT;
                lfsp_pkg::DIR_STRAIGHT: dec_err = 5'sd0;
                lfsp_pkg::DIR_LEFT:     dec_err = lfsp_pkg::ERR_CROSS_LEFT;
                lfsp_pkg::DIR_STOP:     dec_err = 5'sd0;
                default: ;
            endcase
        end

        int_sum = {r_integ[17], r_integ[17], r_integ}
                + {{7{dec_err[4]}}, dec_err, 8'h00};
        int_lim = {3'b000, r_int_limit, 8'h00};
        if (int_sum > int_lim) begin
            int_clamped = int_lim[17:0];
        end else if (int_sum < -int_lim) begin
            int_clamped = 18'(-int_lim);
        end else begin
            int_clamped = int_sum[17:0];
        end
    end

    // steering, decay and wheel terms
    always_comb begin
        acc_rnd   = r_acc + (r_acc[lfsp_pkg::ACC_W-1] ? 36'sh0000FFFF : 36'sh0);
        steer_q   = acc_rnd[lfsp_pkg::ACC_W-1:16];
        int_abs   = r_integ[17] ? 18'(-r_integ) : 18'(r_integ);
        decay_rnd = mul_prod[24:0] + 25'd128;
        wheel_top = {1'b0, r_speed} + {1'b0, r_headroom};
        raw_l     = $signed({4'b0000, r_speed}) + {r_steer[10], r_steer};
        raw_r     = $signed({4'b0000, r_speed}) - {r_steer[10], r_steer};
        wheel_l   = wheel_clamp(raw_l, wheel_top);
        wheel_r   = wheel_clamp(raw_r, wheel_top);
        fac_l     = 10'd256 - {{2{r_trim[7]}}, r_trim};
        fac_r     = 10'd256 + {{2{r_trim[7]}}, r_trim};
    end

    // operation sequencing
    always_comb begin
        n_cross = r_cross;
        n_held  = r_held;
        n_prior = r_prior;
        n_integ = r_integ;
        n_done  = r_done;
        n_diff  = r_diff;
        n_acc   = r_acc;
        n_steer = r_steer;
        n_left  = r_left;
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (i_cmd.op)
            lfsp_pkg::OP_NONE: ;
            lfsp_pkg::OP_DECODE: begin
                n_cross = dec_cross;
                n_done  = dec_done;
                n_held  = dec_err;
                n_prior = dec_err;
                n_diff  = {dec_err[4], dec_err} - {r_prior[4], r_prior};
                n_integ = int_clamped;
            end
            lfsp_pkg::OP_MUL_P: begin
                mul_en = 1'b1;
                mul_a  = {3'b000, r_gain_p};
                mul_b  = {{14{r_held[4]}}, r_held};
            end
            lfsp_pkg::OP_MUL_I: begin
                n_acc  = {mul_prod[27:0], 8'h00};
                mul_en = 1'b1;
                mul_a  = {3'b000, r_gain_i};
                mul_b  = {r_integ[17], r_integ};
            end
            lfsp_pkg::OP_MUL_D: begin
                n_acc  = r_acc + mul_prod[lfsp_pkg::ACC_W-1:0];
                mul_en = 1'b1;
                mul_a  = {3'b000, r_gain_d};
                mul_b  = {{13{r_diff[5]}}, r_diff};
            end
            lfsp_pkg::OP_DECAY: begin
                n_acc  = r_acc + {mul_prod[27:0], 8'h00};
                mul_en = 1'b1;
                mul_a  = {2'b00, int_abs[16:0]};
                mul_b  = lfsp_pkg::DECAY_NUM;
            end
            lfsp_pkg::OP_STEER: begin
                if (steer_q > 20'sd1023) begin
                    n_steer = 11'sd1023;
                end else if (steer_q < -20'sd1024) begin
                    n_steer = -11'sd1024;
                end else begin
                    n_steer = steer_q[10:0];
                end
                // decay only on a centred line, after the PID sum
                if (r_sens == lfsp_pkg::SENS_CENTRE) begin
                    if (int_abs > lfsp_pkg::DECAY_FLOOR) begin
                        n_integ = r_integ[17] ? -$signed({1'b0, decay_rnd[24:8]})
                                              : $signed({1'b0, decay_rnd[24:8]});
                    end else begin
                        n_integ = 18'sd0;
                    end
                end
            end
            lfsp_pkg::OP_WL_SONAR: begin
                mul_en = 1'b1;
                mul_a  = {10'd0, wheel_l};
                mul_b  = {10'd0, r_sonar};
            end
            lfsp_pkg::OP_WL_TRIM: begin
                mul_en = 1'b1;
                mul_a  = mul_prod[lfsp_pkg::MUL_W-1:0];
                mul_b  = {9'd0, fac_l};
            end
            lfsp_pkg::OP_WR_SONAR: begin
                n_left = sat_speed(mul_prod);
                mul_en = 1'b1;
                mul_a  = {10'd0, wheel_r};
                mul_b  = {10'd0, r_sonar};
            end
            lfsp_pkg::OP_WR_TRIM: begin
                mul_en = 1'b1;
                mul_a  = mul_prod[lfsp_pkg::MUL_W-1:0];
                mul_b  = {9'd0, fac_r};
            end
            default: ;
        endcase
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= lfsp_pkg::GAIN_P_RST;
            r_gain_i    <= lfsp_pkg::GAIN_I_RST;
            r_gain_d    <= lfsp_pkg::GAIN_D_RST;
            r_int_limit <= lfsp_pkg::LIMIT_RST;
            r_headroom  <= lfsp_pkg::HEADROOM_RST;
            r_trim      <= lfsp_pkg::TRIM_RST;
            r_cross     <= 1'b0;
            r_held      <= 5'sd0;
            r_prior     <= 5'sd0;
            r_integ     <= 18'sd0;
        end else begin
            r_cross <= n_cross;
            r_held  <= n_held;
            r_prior <= n_prior;
            r_integ <= n_integ;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lfsp_pkg::CFG_GAIN_P:   r_gain_p    <= i_cfg_data;
                    lfsp_pkg::CFG_GAIN_I:   r_gain_i    <= i_cfg_data;
                    lfsp_pkg::CFG_GAIN_D:   r_gain_d    <= i_cfg_data;
                    lfsp_pkg::CFG_LIMIT:    r_int_limit <= i_cfg_data[8:0];
                    lfsp_pkg::CFG_HEADROOM: r_headroom  <= i_cfg_data[7:0];
                    lfsp_pkg::CFG_TRIM:     r_trim      <= $signed(i_cfg_data[7:0]);
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_done  <= n_done;
        r_diff  <= n_diff;
        r_acc   <= n_acc;
        r_steer <= n_steer;
        r_left  <= n_left;
        if (i_cmd.load_in) begin
            r_sens  <= i_line_sensors;
            r_dir   <= i_direction;
            r_speed <= i_drive_speed;
            r_sonar <= i_sonar_factor;
            r_armed <= i_maneuver_armed;
        end
        if (i_cmd.load_out) begin
            r_out_err   <= r_held;
            r_out_steer <= r_steer;
            r_out_left  <= (r_speed == 8'd0) ? 8'd0 : r_left;
            r_out_right <= (r_speed == 8'd0) ? 8'd0 : sat_speed(mul_prod);
            r_out_done  <= r_done;
            r_out_full  <= r_cross;
        end
    end

    assign o_direction_error = r_out_err;
    assign o_steer_value     = r_out_steer;
    assign o_left_speed      = r_out_left;
    assign o_right_speed     = r_out_right;
    assign o_action_done     = r_out_done;
    assign o_in_full_line    = r_out_full;

endmodule

`default_nettype wire

// ===== rtl/lfsp_ctrl.sv =====
// Controller: sequences the datapath and owns both handshakes.
`default_nettype none

module lfsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output lfsp_pkg::t_dp_cmd o_cmd
);

    lfsp_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfsp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd.load_in  = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.op       = lfsp_pkg::OP_NONE;
        unique case (r_state)
            lfsp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = lfsp_pkg::S_DECODE;
                end
            end
            lfsp_pkg::S_DECODE: begin
                o_cmd.op = lfsp_pkg::OP_DECODE;
                n_state  = lfsp_pkg::S_MUL_P;
            end
            lfsp_pkg::S_MUL_P: begin
                o_cmd.op = lfsp_pkg::OP_MUL_P;
                n_state  = lfsp_pkg::S_MUL_I;
            end
            lfsp_pkg::S_MUL_I: begin
                o_cmd.op = lfsp_pkg::OP_MUL_I;
                n_state  = lfsp_pkg::S_MUL_D;
            end
            lfsp_pkg::S_MUL_D: begin
                o_cmd.op = lfsp_pkg::OP_MUL_D;
                n_state  = lfsp_pkg::S_DECAY;
            end
            lfsp_pkg::S_DECAY: begin
                o_cmd.op = lfsp_pkg::OP_DECAY;
                n_state  = lfsp_pkg::S_STEER;
            end
            lfsp_pkg::S_STEER: begin
                o_cmd.op = lfsp_pkg::OP_STEER;
                n_state  = lfsp_pkg::S_WL_SONAR;
            end
            lfsp_pkg::S_WL_SONAR: begin
                o_cmd.op = lfsp_pkg::OP_WL_SONAR;
                n_state  = lfsp_pkg::S_WL_TRIM;
            end
            lfsp_pkg::S_WL_TRIM: begin
                o_cmd.op = lfsp_pkg::OP_WL_TRIM;
                n_state  = lfsp_pkg::S_WR_SONAR;
            end
            lfsp_pkg::S_WR_SONAR: begin
                o_cmd.op = lfsp_pkg::OP_WR_SONAR;
                n_state  = lfsp_pkg::S_WR_TRIM;
            end
            lfsp_pkg::S_WR_TRIM: begin
                o_cmd.op = lfsp_pkg::OP_WR_TRIM;
                n_state  = lfsp_pkg::S_OUT;
            end
            lfsp_pkg::S_OUT: begin
                // hold here until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = lfsp_pkg::S_IDLE;
                end
            end
            default: n_state = lfsp_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == lfsp_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/line_follow_steering_pid.sv =====
// Top level of the five-sensor line follower with PID steering.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | sensors, direction, speed, sonar, armed
//  out     | from block| o_out_valid / i_out_ready | error, steer, left/right speed, flags
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A transaction runs from acceptance to a valid result in these steps: accept,
// decode, three gain products, the decay product, steering, four wheel products
// and the result load. The single 19x19 multiplier makes the steps run in turn.
// Reset is synchronous, active low: configuration registers go to their defaults
// and the loop state clears at once. A result that is not taken stays in the
// result register; the next transaction is accepted and worked up to the load step.
`default_nettype none

module line_follow_steering_pid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [4:0]         i_line_sensors,
    input  logic [2:0]         i_direction,
    input  logic [7:0]         i_drive_speed,
    input  logic [8:0]         i_sonar_factor,
    input  logic               i_maneuver_armed,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [4:0]  o_direction_error,
    output logic signed [10:0] o_steer_value,
    output logic [7:0]         o_left_speed,
    output logic [7:0]         o_right_speed,
    output logic               o_action_done,
    output logic               o_in_full_line,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    lfsp_pkg::t_dp_cmd cmd;

    // writes are taken in any cycle; the user must issue them only while idle, the block does not enforce this
    assign o_cfg_ready = 1'b1;

    lfsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lfsp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_line_sensors    (i_line_sensors),
        .i_direction       (i_direction),
        .i_drive_speed     (i_drive_speed),
        .i_sonar_factor    (i_sonar_factor),
        .i_maneuver_armed  (i_maneuver_armed),
        .o_direction_error (o_direction_error),
        .o_steer_value     (o_steer_value),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_action_done     (o_action_done),
        .o_in_full_line    (o_in_full_line)
    );

endmodule

`default_nettype wire

// ===== rtl/lfsp_checker.sv =====
// Port-level checks of the steering PID, bound to the top level.
`default_nettype none

`include "line_follow_steering_pid_defines.svh"

module lfsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [4:0]  o_direction_error,
    input logic signed [10:0] o_steer_value,
    input logic [7:0]         o_left_speed,
    input logic [7:0]         o_right_speed,
    input logic               o_action_done,
    input logic               o_in_full_line
);

    // decoded or forced error never leaves -10..10
    `LFSP_ASSERT_IMP(a_err_range, o_out_valid, (o_direction_error <= 5'sd10) && (o_direction_error >= -5'sd10))

    // the done pulse comes with the mode already left
    `LFSP_ASSERT_IMP(a_done_leaves_mode, o_out_valid && o_action_done, !o_in_full_line)

    // one transaction at a time
    `LFSP_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // a waiting result is not overwritten by the next transaction
    `LFSP_ASSERT_NXT(a_result_held, o_out_valid && !i_out_ready, o_out_valid && $stable(o_steer_value) && $stable(o_left_speed) && $stable(o_right_speed))

endmodule

bind line_follow_steering_pid lfsp_checker u_lfsp_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for line_follow_steering_pid: directed table, then randomised phases checked by a predictor.
`timescale 1ns / 100ps

module testbench;
    import lfsp_pkg::*;

    // direction codes with no package name: no command, and the spare codes
    localparam logic [2:0] DIR_NONE     = 3'd4;
    localparam logic [2:0] DIR_SPARE_LO = 3'd5;
    localparam logic [2:0] DIR_SPARE_HI = 3'd7;

    // patterns outside the decode set
    localparam logic [4:0] SENS_SPLIT  = 5'h15;
    localparam logic [4:0] SENS_INNER  = 5'h0E;
    localparam logic [4:0] SENS_GAPPED = 5'h1B;

    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 6;
    localparam int PHASE_TICKS  = 305;
    localparam int NUM_ROWS     = 23;

    typedef struct packed {
        logic [4:0] sens;
        logic [2:0] dir;
        logic [7:0] speed;
        logic [8:0] sonar;
        logic       armed;
    } tick_t;

    typedef struct packed {
        t_err               err;
        logic signed [10:0] steer;
        logic [7:0]         left;
        logic [7:0]         right;
        logic               done;
        logic               full;
    } steer_cmd_t;

    typedef struct packed {
        tick_t      stim;
        logic       typed;
        steer_cmd_t want;
    } row_t;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] clamp;
        logic [15:0] headroom;
        logic [15:0] trim;
    } settings_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [4:0]         i_line_sensors = '0;
    logic [2:0]         i_direction = '0;
    logic [7:0]         i_drive_speed = '0;
    logic [8:0]         i_sonar_factor = '0;
    logic               i_maneuver_armed = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [4:0]  o_direction_error;
    logic signed [10:0] o_steer_value;
    logic [7:0]         o_left_speed;
    logic [7:0]         o_right_speed;
    logic               o_action_done;
    logic               o_in_full_line;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    line_follow_steering_pid i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_line_sensors    (i_line_sensors),
        .i_direction       (i_direction),
        .i_drive_speed     (i_drive_speed),
        .i_sonar_factor    (i_sonar_factor),
        .i_maneuver_armed  (i_maneuver_armed),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_direction_error (o_direction_error),
        .o_steer_value     (o_steer_value),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_action_done     (o_action_done),
        .o_in_full_line    (o_in_full_line),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the registers and the loop state
    int  kp_now, ki_now, kd_now, clamp_now, headroom_now, trim_now;
    bit  on_crossing;
    int  last_error, prev_error, integ_q8;

    steer_cmd_t expected_cmds[$];
    int         mismatches = 0;
    int         send_gap_pct;
    int         recv_gap_pct;
    logic       stall_req = 1'b0;

    localparam logic [4:0] TRACK_PATS [12] = '{
        SENS_R4, SENS_R3, SENS_R2, SENS_R1, SENS_CENTRE, SENS_L1,
        SENS_L2, SENS_L3, SENS_L4, SENS_HARD_L, SENS_HARD_R, SENS_CENTRE
    };

    // directed ticks; typed rows hold values that follow directly from reset
    // settings (gain_p 1.0, other gains 0, headroom 50, trim -3)
    row_t plan [NUM_ROWS] = '{
        '{'{SENS_CENTRE, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{5'sd0, 11'sd0, 8'd101, 8'd98, 1'b0, 1'b0}},
        '{'{SENS_R4, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{5'sd4, 11'sd4, 8'd105, 8'd94, 1'b0, 1'b0}},
        // line lost after +4
        '{'{SENS_NONE, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{5'sd5, 11'sd5, 8'd106, 8'd93, 1'b0, 1'b0}},
        '{'{SENS_L4, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{-5'sd4, -11'sd4, 8'd97, 8'd102, 1'b0, 1'b0}},
        // line lost after -4
        '{'{SENS_NONE, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{-5'sd5, -11'sd5, 8'd96, 8'd103, 1'b0, 1'b0}},
        // lost again without a held 4: error kept
        '{'{SENS_NONE, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{-5'sd5, -11'sd5, 8'd96, 8'd103, 1'b0, 1'b0}},
        // unknown pattern: error kept
        '{'{SENS_SPLIT, DIR_STRAIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{-5'sd5, -11'sd5, 8'd96, 8'd103, 1'b0, 1'b0}},
        // zero speed stops both wheels
        '{'{SENS_HARD_L, DIR_STRAIGHT, 8'd0, 9'd256, 1'b0}, 1'b1,
          '{-5'sd10, -11'sd10, 8'd0, 8'd0, 1'b0, 1'b0}},
        // full speed, left wheel saturates
        '{'{SENS_HARD_R, DIR_STRAIGHT, 8'd255, 9'd256, 1'b0}, 1'b1,
          '{5'sd10, 11'sd10, 8'd255, 8'd242, 1'b0, 1'b0}},
        // enter full-line mode, not armed
        '{'{SENS_FULL, DIR_RIGHT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{5'sd5, 11'sd5, 8'd106, 8'd93, 1'b0, 1'b1}},
        // no command keeps the error; ends not clear so no exit
        '{'{SENS_FULL, DIR_NONE, 8'd100, 9'd256, 1'b1}, 1'b1,
          '{5'sd5, 11'sd5, 8'd106, 8'd93, 1'b0, 1'b1}},
        '{'{SENS_INNER, DIR_LEFT, 8'd100, 9'd256, 1'b0}, 1'b1,
          '{-5'sd5, -11'sd5, 8'd96, 8'd103, 1'b0, 1'b1}},
        // ends clear and armed: exit with done pulse
        '{'{SENS_INNER, DIR_STRAIGHT, 8'd100, 9'd256, 1'b1}, 1'b1,
          '{5'sd0, 11'sd0, 8'd101, 8'd98, 1'b1, 1'b0}},
        // stop command enters and leaves on the same tick
        '{'{SENS_FULL, DIR_STOP, 8'd100, 9'd256, 1'b1}, 1'b1,
          '{5'sd0, 11'sd0, 8'd101, 8'd98, 1'b1, 1'b0}},
        '{'{SENS_L1, DIR_STRAIGHT, 8'd255, 9'd0, 1'b0}, 1'b1,
          '{-5'sd1, -11'sd1, 8'd0, 8'd0, 1'b0, 1'b0}},
        // sonar factor above full scale, left wheel clamped at zero
        '{'{SENS_L2, DIR_STRAIGHT, 8'd1, 9'd511, 1'b1}, 1'b1,
          '{-5'sd2, -11'sd2, 8'd0, 8'd5, 1'b0, 1'b0}},
        '{'{SENS_L3, DIR_RIGHT, 8'd37, 9'd128, 1'b1}, 1'b0, '0},
        '{'{SENS_R3, DIR_LEFT, 8'd200, 9'd300, 1'b0}, 1'b0, '0},
        '{'{SENS_R2, DIR_STOP, 8'd128, 9'd256, 1'b1}, 1'b0, '0},
        '{'{SENS_R1, DIR_NONE, 8'd64, 9'd200, 1'b0}, 1'b0, '0},
        '{'{SENS_FULL, DIR_SPARE_HI, 8'd90, 9'd256, 1'b0}, 1'b0, '0},
        '{'{SENS_GAPPED, DIR_SPARE_LO, 8'd90, 9'd256, 1'b1}, 1'b0, '0},
        '{'{SENS_NONE, DIR_STOP, 8'd90, 9'd256, 1'b1}, 1'b0, '0}
    };

    function automatic void reset_predictor();
        kp_now       = int'(GAIN_P_RST);
        ki_now       = int'(GAIN_I_RST);
        kd_now       = int'(GAIN_D_RST);
        clamp_now    = int'(LIMIT_RST);
        headroom_now = int'(HEADROOM_RST);
        trim_now     = int'(TRIM_RST);
        on_crossing  = 1'b0;
        last_error   = 0;
        prev_error   = 0;
        integ_q8     = 0;
    endfunction

    function automatic logic [7:0] wheel_cmd(input int raw, input int top, input int sonar,
                                             input int factor);
        longint v, p;
        v = raw < 0 ? 0 : (raw > top ? top : raw);
        p = (v * sonar * factor) >> 16;
        return p > 255 ? 8'd255 : p[7:0];
    endfunction

    function automatic steer_cmd_t predict_command(input tick_t t);
        steer_cmd_t c;
        int         e, lim_q8, slope, mag, wheel_top;
        longint     pid_sum, pid_int;
        bit         finished;
        e = last_error;
        finished = 1'b0;
        if (!on_crossing) begin
            case (t.sens)
                SENS_R4:     e = 4;
                SENS_R3:     e = 3;
                SENS_R2:     e = 2;
                SENS_R1:     e = 1;
                SENS_CENTRE: e = 0;
                SENS_L1:     e = -1;
                SENS_L2:     e = -2;
                SENS_L3:     e = -3;
                SENS_L4:     e = -4;
                SENS_HARD_L: e = -10;
                SENS_HARD_R: e = 10;
                SENS_FULL:   on_crossing = 1'b1;
                SENS_NONE: begin
                    if (e == -4) e = -5;
                    else if (e == 4) e = 5;
                end
                default: ;
            endcase
        end
        // full-line mode is evaluated on the tick it is entered
        if (on_crossing) begin
            if (((t.sens & SENS_ENDS) == 5'd0 || t.dir == DIR_STOP) && t.armed) begin
                on_crossing = 1'b0;
                finished = 1'b1;
            end
            case (t.dir)
                DIR_RIGHT:    e = ERR_CROSS_RIGHT;
                DIR_STRAIGHT: e = 0;
                DIR_LEFT:     e = ERR_CROSS_LEFT;
                DIR_STOP:     e = 0;
                default: ;
            endcase
        end
        last_error = e;

        lim_q8 = clamp_now * 256;
        integ_q8 = integ_q8 + e * 256;
        if (integ_q8 > lim_q8) integ_q8 = lim_q8;
        if (integ_q8 < -lim_q8) integ_q8 = -lim_q8;

        slope = e - prev_error;
        prev_error = e;

        pid_sum = longint'(kp_now) * e * 256 + longint'(ki_now) * integ_q8
                + longint'(kd_now) * slope * 256;
        // truncate toward zero, then saturate
        if (pid_sum < 0) pid_int = -((-pid_sum) >> 16);
        else pid_int = pid_sum >> 16;
        if (pid_int > 1023) pid_int = 1023;
        if (pid_int < -1024) pid_int = -1024;

        // decay after the sum: x243/256 rounded, or to zero at or below ten units
        if (t.sens == SENS_CENTRE) begin
            mag = integ_q8 < 0 ? -integ_q8 : integ_q8;
            if (mag > 10 * 256) begin
                mag = (mag * 243 + 128) >> 8;
                integ_q8 = integ_q8 < 0 ? -mag : mag;
            end else begin
                integ_q8 = 0;
            end
        end

        c.err = e[4:0];
        c.steer = pid_int[10:0];
        c.left = 8'd0;
        c.right = 8'd0;
        if (t.speed != 8'd0) begin
            wheel_top = int'(t.speed) + headroom_now;
            c.left = wheel_cmd(int'(t.speed) + int'(pid_int), wheel_top, int'(t.sonar),
                               256 - trim_now);
            c.right = wheel_cmd(int'(t.speed) - int'(pid_int), wheel_top, int'(t.sonar),
                                256 + trim_now);
        end
        c.done = finished;
        c.full = on_crossing;
        return c;
    endfunction

    // mostly track patterns, some lost-line and full-line ticks, some noise
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 55) t.sens = TRACK_PATS[$urandom_range(11)];
        else if (pick < 68) t.sens = SENS_NONE;
        else if (pick < 78) t.sens = SENS_FULL;
        else if (pick < 88) t.sens = 5'($urandom) & ~SENS_ENDS;
        else t.sens = 5'($urandom);
        t.dir = 3'($urandom_range(7));
        t.armed = ($urandom_range(2) == 0);
        pick = $urandom_range(15);
        if (pick == 0) t.speed = 8'd0;
        else if (pick == 1) t.speed = 8'd255;
        else t.speed = 8'($urandom_range(255));
        pick = $urandom_range(9);
        if (pick < 7) t.sonar = 9'($urandom_range(256));
        else if (pick == 7) t.sonar = 9'd256;
        else t.sonar = 9'($urandom_range(511, 257));
        return t;
    endfunction

    function automatic settings_t phase_settings(input int ph);
        settings_t s;
        case (ph)
            0: s = '{16'd256, 16'd64, 16'd128, 16'd300, 16'd50, 16'h00FD};
            1: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd511, 16'd255, 16'h007F};
            2: s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0080};
            3: s = '{16'($urandom_range(1023)), 16'($urandom_range(1023)),
                     16'($urandom_range(1023)), 16'($urandom_range(511)),
                     16'($urandom_range(255)), 16'($urandom_range(255))};
            4: s = '{16'd512, 16'd256, 16'd1024, 16'd100, 16'd20, 16'h0000};
            default: s = '{16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(511)), 16'($urandom_range(255)),
                           16'($urandom_range(255))};
        endcase
        return s;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:   kp_now = int'(val);
            CFG_GAIN_I:   ki_now = int'(val);
            CFG_GAIN_D:   kd_now = int'(val);
            CFG_LIMIT:    clamp_now = int'(val[8:0]);
            CFG_HEADROOM: headroom_now = int'(val[7:0]);
            CFG_TRIM:     trim_now = $signed(val[7:0]);
            default: ;
        endcase
    endtask

    task automatic program_settings(input settings_t s);
        write_reg(CFG_GAIN_P, s.kp);
        write_reg(CFG_GAIN_I, s.ki);
        write_reg(CFG_GAIN_D, s.kd);
        write_reg(CFG_LIMIT, s.clamp);
        write_reg(CFG_HEADROOM, s.headroom);
        write_reg(CFG_TRIM, s.trim);
        i_cfg_valid <= 1'b0;
    endtask

    // offer one tick; the expectation is queued once the block takes it
    task automatic offer_tick(input tick_t t, input logic typed, input steer_cmd_t want);
        steer_cmd_t predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_line_sensors   <= t.sens;
        i_direction      <= t.dir;
        i_drive_speed    <= t.speed;
        i_sonar_factor   <= t.sonar;
        i_maneuver_armed <= t.armed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_command(t);
        expected_cmds.push_back(typed ? want : predicted);
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic match_field(input string name, input integer want, input integer got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        steer_cmd_t w;
        if (expected_cmds.size() == 0) begin
            $error("result transaction with nothing outstanding");
            mismatches++;
        end else begin
            w = expected_cmds.pop_front();
            match_field("direction_error", w.err, o_direction_error);
            match_field("steer_value", w.steer, o_steer_value);
            match_field("left_speed", w.left, o_left_speed);
            match_field("right_speed", w.right, o_right_speed);
            match_field("action_done", w.done, o_action_done);
            match_field("in_full_line", w.full, o_in_full_line);
        end
    endtask

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge i_clk) begin : result_side
        int hold_left;
        bit hold_taken;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            if (stall_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int ph, n, r;
        reset_predictor();
        send_gap_pct = 37;
        recv_gap_pct = 49;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++) offer_tick(plan[r].stim, plan[r].typed, plan[r].want);
        drain_block();

        for (ph = 0; ph < PHASES; ph++) begin
            program_settings(phase_settings(ph));
            if (ph >= 4) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end else if (ph >= 2) begin
                send_gap_pct = 49;
                recv_gap_pct = 37;
            end
            for (n = 0; n < PHASE_TICKS; n++) begin
                // long receiver hold while ticks keep coming
                if (ph == 0 && n == 40) stall_req <= 1'b1;
                offer_tick(random_tick(), 1'b0, '0);
            end
            drain_block();
        end

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
